FILE: hdl/sawtc_pkg.sv
// shared types and constants of the set associative write-through cache
package sawtc_pkg;

   localparam int unsigned SetCount  = 128;
   localparam int unsigned WayCount  = 8;
   localparam int unsigned LineBytes = 64;
   localparam int unsigned WordsPerLine = LineBytes / 4;
   localparam int unsigned OffBits  = $clog2(LineBytes);
   localparam int unsigned SetBits  = $clog2(SetCount);
   localparam int unsigned WayBits  = (WayCount > 1) ? $clog2(WayCount) : 1;
   localparam int unsigned TagBits  = 32 - OffBits - SetBits;
   localparam int unsigned WidxBits = $clog2(WordsPerLine);
   localparam int unsigned SlotBits = SetBits + WayBits;
   localparam int unsigned WaddrBits = SlotBits + WidxBits;
   localparam int unsigned LineNumBits = 32 - OffBits;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FILL  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_LOOK2,
      ST_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;     // register request word, read tag memory for first word
      logic look2;    // read tag memory for second word
      logic finish;   // update stores and miss state from the lookups
      logic rsp_load; // latch response
   } cmd_type;

   typedef struct packed {
      logic crosses;  // read or write access spans two 32-bit words
   } status_type;

endpackage

FILE: hdl/sawtc_if.sv
// valid/ready channel interfaces for request and response words
interface sawtc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] address;
   logic [2:0]  length;
   logic [31:0] write_data;
   logic [3:0]  fill_word_index;
   logic [31:0] fill_data;
   modport source (output valid, action, address, length, write_data, fill_word_index,
                   fill_data, input ready);
   modport sink (input valid, action, address, length, write_data, fill_word_index,
                 fill_data, output ready);
endinterface

interface sawtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        hit;
   logic [25:0] miss_line_address;
   logic        mem_write_enable;
   logic [31:0] mem_write_address;
   logic [2:0]  mem_write_length;
   logic [31:0] mem_write_data;
   logic        fill_done;
   modport source (output valid, read_data, hit, miss_line_address, mem_write_enable,
                   mem_write_address, mem_write_length, mem_write_data, fill_done,
                   input ready);
   modport sink (input valid, read_data, hit, miss_line_address, mem_write_enable,
                 mem_write_address, mem_write_length, mem_write_data, fill_done,
                 output ready);
endinterface

FILE: hdl/set_assoc_write_through_cache.sv
// top level of the 8-way set associative write-through cache
//
// usage
//  - req channel carries one word: action (read, write, fill), address, length,
//    write data, fill word index and fill data; accepted when valid and ready
//  - rsp channel returns exactly one word per request: read data, hit, miss line,
//    write-through fields and fill done
//  - csr port loads the replacement lfsr seed; write only while idle
// timing
//  - one request at a time; the response becomes valid after the registered tag
//    read followed by the registered data word read for each word: one word when
//    the bytes sit in one 32-bit word, two when they span two words (in the same
//    line or the next)
//  - ready rises again together with response valid, so a new request is not
//    taken before the response of the last one is loaded
// reset
//  - synchronous, clears every valid bit, the pending miss and the lfsr (seed 1)
// stalls
//  - the response waits in its output register; a new request is taken while it
//    waits, but that one is held before its own response until the first is taken
module set_assoc_write_through_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   sawtc_req_if.sink   req,
   sawtc_rsp_if.source rsp
);
   import sawtc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   sawtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, lookup and response register
   sawtc_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_action            (req.action),
      .req_address           (req.address),
      .req_length            (req.length),
      .req_write_data        (req.write_data),
      .req_fill_word_index   (req.fill_word_index),
      .req_fill_data         (req.fill_data),
      .cmd                   (cmd),
      .status                (status),
      .rsp_read_data         (rsp.read_data),
      .rsp_hit               (rsp.hit),
      .rsp_miss_line_address (rsp.miss_line_address),
      .rsp_mem_write_enable  (rsp.mem_write_enable),
      .rsp_mem_write_address (rsp.mem_write_address),
      .rsp_mem_write_length  (rsp.mem_write_length),
      .rsp_mem_write_data    (rsp.mem_write_data),
      .rsp_fill_done         (rsp.fill_done)
   );
endmodule

FILE: hdl/sawtc_ctrl.sv
// controller state machine sequencing lookups and response
module sawtc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sawtc_pkg::status_type  status,
   output sawtc_pkg::cmd_type     cmd
);
   import sawtc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (status.crosses) begin
               cmd.look2 = 1'b1;
               state_in  = ST_LOOK2;
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_LOOK2: state_in = ST_DATA;
         // last data word lands in its holding register
         ST_DATA: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish    = 1'b1;
               cmd.rsp_load  = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: hdl/sawtc_dp.sv
// datapath: tag, valid and data stores, lookup, fill and lfsr
module sawtc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   input  logic [1:0]            req_action,
   input  logic [31:0]           req_address,
   input  logic [2:0]            req_length,
   input  logic [31:0]           req_write_data,
   input  logic [3:0]            req_fill_word_index,
   input  logic [31:0]           req_fill_data,
   input  sawtc_pkg::cmd_type    cmd,
   output sawtc_pkg::status_type status,
   output logic [31:0]           rsp_read_data,
   output logic                  rsp_hit,
   output logic [25:0]           rsp_miss_line_address,
   output logic                  rsp_mem_write_enable,
   output logic [31:0]           rsp_mem_write_address,
   output logic [2:0]            rsp_mem_write_length,
   output logic [31:0]           rsp_mem_write_data,
   output logic                  rsp_fill_done
);
   import sawtc_pkg::*;

   localparam int unsigned Slots = SetCount * WayCount;
   localparam int unsigned DataWords = Slots * WordsPerLine;

   // stores, one tag entry holds all ways of a set
   logic [Slots-1:0]            valid_ff;
   logic [WayCount*TagBits-1:0] tag_mem [SetCount];
   logic [31:0]                 data_mem [DataWords];

   // request word
   logic [1:0]  act_ff;
   logic [31:0] addr_ff, wdata_ff, fdata_ff;
   logic [2:0]  len_ff;
   logic [3:0]  fidx_ff;

   // pending miss
   logic [SetBits-1:0] pset_ff;
   logic [WayBits-1:0] pway_ff;
   logic [TagBits-1:0] ptag_ff;
   logic [WordsPerLine-1:0] fmask_ff;
   logic               pact_ff;
   logic [15:0]        lfsr_ff;

   // lookup results per word (0 first, 1 second)
   logic [WayCount*TagBits-1:0] tags_ff;   // registered tag read, line being looked up
   logic [1:0]                  lhit_ff;
   logic [WayBits-1:0]          lway0_ff, lway1_ff;
   logic                        look_sel_ff; // which word tags_ff belongs to
   logic                        look_pend_ff;
   logic [31:0]                 word0_ff, word1_ff;

   logic [2:0]  len_n;
   logic [31:0] last_addr;
   logic [LineNumBits-1:0] line0, line1;

   always_comb begin
      len_n = len_ff;
      if (len_ff == 3'd0) len_n = 3'd1;
      else if (len_ff > 3'd4) len_n = 3'd4;
      last_addr = addr_ff + {29'd0, len_n} - 32'd1;
   end
   assign line0 = addr_ff[31:OffBits];
   assign line1 = last_addr[31:OffBits];
   // second word may sit in the same line or in the next one
   assign status.crosses = (addr_ff[31:2] != last_addr[31:2]) &&
                           (act_ff == ACT_READ || act_ff == ACT_WRITE);

   // tag read: issued by load (first word) or look2 (second word)
   logic [SetBits-1:0] rd_set;
   logic [LineNumBits-1:0] load_line;
   assign load_line = req_address[31:OffBits];
   assign rd_set = cmd.load ? load_line[SetBits-1:0] : line1[SetBits-1:0];

   always_ff @(posedge clock) begin
      tags_ff <= tag_mem[rd_set];
   end

   // tag compare on registered tags
   logic [TagBits-1:0] cmp_tag;
   logic               any_hit;
   logic [WayBits-1:0] hit_way;
   logic [LineNumBits-1:0] look_line;
   logic [SetBits-1:0] look_set;
   assign look_line = look_sel_ff ? line1 : line0;
   assign look_set  = look_line[SetBits-1:0];
   assign cmp_tag   = look_line[LineNumBits-1:SetBits];
   always_comb begin
      any_hit = 1'b0;
      hit_way = '0;
      for (int w = WayCount - 1; w >= 0; w--) begin
         if (valid_ff[{look_set, WayBits'(w)}] &&
             tags_ff[w*TagBits +: TagBits] == cmp_tag) begin
            any_hit = 1'b1;
            hit_way = WayBits'(w);
         end
      end
   end

   // data word read address for the looked-up word
   logic [WidxBits-1:0] widx;
   logic [31:0] look_addr;
   assign look_addr = look_sel_ff ? last_addr : addr_ff;
   assign widx = look_addr[OffBits-1:2];

   logic [31:0] word_rd_ff;
   always_ff @(posedge clock) begin
      word_rd_ff <= data_mem[{look_set, hit_way, widx}];
   end

   // victim choice
   logic               inval_found;
   logic [WayBits-1:0] inval_way;
   logic [15:0]        lfsr_step;
   always_comb begin
      inval_found = 1'b0;
      inval_way   = '0;
      for (int w = WayCount - 1; w >= 0; w--) begin
         if (!valid_ff[{look_set, WayBits'(w)}]) begin
            inval_found = 1'b1;
            inval_way   = WayBits'(w);
         end
      end
      lfsr_step = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? 16'hb400 : 16'h0000);
   end

   // byte assembly
   logic [31:0] rdata;
   logic [31:0] wkeep;
   logic        all_hit;
   logic        miss1st;
   logic [LineNumBits-1:0] miss_line;
   logic [7:0]  bsel;
   logic [31:0] bpos;
   logic        bline;
   always_comb begin
      rdata = '0;
      for (int j = 0; j < 4; j++) begin
         bpos  = addr_ff + 32'(j);
         bline = (bpos[31:2] != addr_ff[31:2]);
         bsel  = '0;
         if (3'(j) < len_n) begin
            if (!bline) bsel = word0_ff[bpos[1:0]*8 +: 8];
            else        bsel = word1_ff[bpos[1:0]*8 +: 8];
         end
         rdata[j*8 +: 8] = bsel;
      end
      case (len_n)
         3'd1: wkeep = 32'h0000_00ff;
         3'd2: wkeep = 32'h0000_ffff;
         3'd3: wkeep = 32'h00ff_ffff;
         default: wkeep = 32'hffff_ffff;
      endcase
      miss1st  = !lhit_ff[0];
      all_hit  = lhit_ff[0] && (lhit_ff[1] || !status.crosses);
      miss_line = miss1st ? line0 : line1;
   end

   // fill path
   logic        fill_ok;
   logic [WordsPerLine-1:0] fmask_new;
   assign fill_ok = pact_ff && (act_ff == ACT_FILL) && (32'(fidx_ff) < WordsPerLine);
   assign fmask_new = fmask_ff | (WordsPerLine'(1) << fidx_ff[WidxBits-1:0]);

   // victim way for a read miss, taken from snapshot of set at miss lookup
   logic [SetBits-1:0] mset;
   assign mset = miss_line[SetBits-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         addr_ff  <= req_address;
         len_ff   <= req_length;
         wdata_ff <= req_write_data;
         fidx_ff  <= req_fill_word_index;
         fdata_ff <= req_fill_data;
      end
   end

   // lookup sequencing: look_sel_ff marks second word, look_pend_ff a compare due
   always_ff @(posedge clock) begin
      if (reset) begin
         look_pend_ff <= 1'b0;
         look_sel_ff  <= 1'b0;
      end else begin
         look_pend_ff <= cmd.load | cmd.look2;
         look_sel_ff  <= cmd.look2;
      end
   end

   // victim decision kept from lookup of the missing line
   logic               vic_inval_ff [2];
   logic [WayBits-1:0] vic_way_ff [2];
   always_ff @(posedge clock) begin
      if (look_pend_ff) begin
         if (!look_sel_ff) begin
            lhit_ff[0]  <= any_hit;
            lway0_ff    <= hit_way;
            vic_inval_ff[0] <= inval_found;
            vic_way_ff[0]   <= inval_way;
         end else begin
            lhit_ff[1]  <= any_hit;
            lway1_ff    <= hit_way;
            vic_inval_ff[1] <= inval_found;
            vic_way_ff[1]   <= inval_way;
         end
      end
   end

   // data word arrives in the cycle after the compare
   logic look_data_ff, look_data_sel_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         look_data_ff     <= 1'b0;
         look_data_sel_ff <= 1'b0;
      end else begin
         look_data_ff     <= look_pend_ff;
         look_data_sel_ff <= look_sel_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (look_data_ff) begin
         if (!look_data_sel_ff) word0_ff <= word_rd_ff;
         else                   word1_ff <= word_rd_ff;
      end
   end

   // write merging per word, on finish
   logic [31:0] merged0, merged1;
   logic [31:0] mpos;
   logic        mline;
   always_comb begin
      merged0 = word0_ff;
      merged1 = word1_ff;
      for (int j = 0; j < 4; j++) begin
         mpos  = addr_ff + 32'(j);
         mline = (mpos[31:2] != addr_ff[31:2]);
         if (3'(j) < len_n) begin
            if (!mline) merged0[mpos[1:0]*8 +: 8] = wdata_ff[j*8 +: 8];
            else        merged1[mpos[1:0]*8 +: 8] = wdata_ff[j*8 +: 8];
         end
      end
   end

   logic [WayBits-1:0] victim;
   logic [WayBits-1:0] lfsr_way;
   assign lfsr_way = lfsr_step[WayBits-1:0];
   always_comb begin
      if (miss1st) victim = vic_inval_ff[0] ? vic_way_ff[0] : lfsr_way;
      else         victim = vic_inval_ff[1] ? vic_way_ff[1] : lfsr_way;
   end
   logic need_lfsr;
   assign need_lfsr = miss1st ? !vic_inval_ff[0] : !vic_inval_ff[1];

   // state updates at finish
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pset_ff  <= '0;
         pway_ff  <= '0;
         ptag_ff  <= '0;
         fmask_ff <= '0;
         pact_ff  <= 1'b0;
         lfsr_ff  <= 16'd1;
      end else begin
         if (csr_write_enable) lfsr_ff <= csr_write_data;
         if (cmd.finish) begin
            if (act_ff == ACT_READ && !all_hit) begin
               valid_ff[{mset, victim}] <= 1'b0;
               pset_ff  <= mset;
               pway_ff  <= victim;
               ptag_ff  <= miss_line[LineNumBits-1:SetBits];
               fmask_ff <= '0;
               pact_ff  <= 1'b1;
               if (need_lfsr) lfsr_ff <= lfsr_step;
            end
            if (fill_ok) begin
               fmask_ff <= fmask_new;
               if (&fmask_new) begin
                  valid_ff[{pset_ff, pway_ff}] <= 1'b1;
                  pact_ff <= 1'b0;
               end
            end
         end
      end
   end

   // memory writes at finish
   logic [SetBits-1:0] set1;
   assign set1 = line1[SetBits-1:0];
   always_ff @(posedge clock) begin
      if (cmd.finish && fill_ok && (&fmask_new))
         tag_mem[pset_ff][pway_ff*TagBits +: TagBits] <= ptag_ff;
   end
   // second word of a crossing write lands in the cycle after the first, through a holding stage
   logic        w2_ff;
   logic [WaddrBits-1:0] w2_addr_ff;
   logic [31:0] w2_data_ff;
   always_ff @(posedge clock) begin
      if (reset) w2_ff <= 1'b0;
      else w2_ff <= cmd.finish && act_ff == ACT_WRITE && status.crosses && lhit_ff[1];
      w2_addr_ff <= {set1, lway1_ff, last_addr[OffBits-1:2]};
      w2_data_ff <= merged1;
   end
   // one write port: the held second word never meets a finish
   always_ff @(posedge clock) begin
      if (w2_ff)
         data_mem[w2_addr_ff] <= w2_data_ff;
      else if (cmd.finish) begin
         if (fill_ok)
            data_mem[{pset_ff, pway_ff, fidx_ff[WidxBits-1:0]}] <= fdata_ff;
         else if (act_ff == ACT_WRITE && lhit_ff[0])
            data_mem[{line0[SetBits-1:0], lway0_ff, addr_ff[OffBits-1:2]}] <= merged0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_read_data         <= '0;
         rsp_hit               <= 1'b0;
         rsp_miss_line_address <= '0;
         rsp_mem_write_enable  <= 1'b0;
         rsp_mem_write_address <= '0;
         rsp_mem_write_length  <= '0;
         rsp_mem_write_data    <= '0;
         rsp_fill_done         <= 1'b0;
         if (act_ff == ACT_READ || act_ff == ACT_WRITE) rsp_hit <= all_hit;
         if (act_ff == ACT_READ) begin
            if (all_hit) rsp_read_data <= rdata;
            else         rsp_miss_line_address <= 26'(miss_line);
         end
         if (act_ff == ACT_WRITE) begin
            rsp_mem_write_enable  <= 1'b1;
            rsp_mem_write_address <= addr_ff;
            rsp_mem_write_length  <= len_n;
            rsp_mem_write_data    <= wdata_ff & wkeep;
         end
         if (fill_ok && (&fmask_new)) rsp_fill_done <= 1'b1;
      end
   end
endmodule
